>>> rtl/core/srr_pkg.sv
`default_nettype none

package srr_pkg;

  localparam int SEQ_W     = 31;
  localparam int CHK_W     = 32;
  localparam int WS_W      = 4;
  localparam int PAY_MAX   = 20;
  localparam int PAY_W     = PAY_MAX * 8;
  localparam int SUM_LANES = 4;
  localparam int SUM_STEPS = PAY_MAX / SUM_LANES;
  localparam int STEP_W    = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 1;

  localparam logic [WS_W-1:0]   WS_RESET    = 4'd8;
  localparam logic [APB_AW-1:0] CFG_ADDR_WS = 1'b0;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic [SEQ_W-1:0]        seq_number;
    logic [SEQ_W-1:0]        ack_number_in;
    logic signed [CHK_W-1:0] checksum_in;
    logic [63:0]             payload_lo;
    logic [63:0]             payload_mid;
    logic [31:0]             payload_hi;
  } srr_in_t;

  typedef struct packed {
    logic                    kind;
    logic [SEQ_W-1:0]        ack_out;
    logic signed [CHK_W-1:0] ack_checksum;
    logic [63:0]             deliver_lo;
    logic [63:0]             deliver_mid;
    logic [31:0]             deliver_hi;
    logic                    last;
  } srr_out_t;

  typedef struct packed {
    logic              load;
    logic              add;
    logic [STEP_W-1:0] step;
    logic              emit_ack;
    logic              emit_pkt;
    logic              emit_buf;
    logic              last;
  } srr_cmd_t;

  typedef struct packed {
    logic chk_ok;
    logic in_win;
    logic in_order;
    logic nxt_valid;
    logic out_free;
  } srr_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_ACK,
    ST_DELIV,
    ST_DRAIN
  } srr_state_t;

endpackage

`default_nettype wire

>>> rtl/core/srr_if.sv
`default_nettype none

interface srr_in_if;
  import srr_pkg::*;
  logic    valid;
  logic    ready;
  srr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srr_out_if;
  import srr_pkg::*;
  logic     valid;
  logic     ready;
  srr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/srr_ctrl.sv
`default_nettype none

module srr_ctrl #(
  parameter int WINDOW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire srr_pkg::srr_sts_t sts,
  output srr_pkg::srr_cmd_t     cmd
);
  import srr_pkg::*;

  localparam int CW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  srr_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CW-1:0]     chain_r, chain_nxt;
  logic              last_ack, last_deliv, last_drain;

  assign last_ack   = !(sts.in_win && sts.in_order);
  assign last_deliv = (WINDOW == 1) || !sts.nxt_valid;
  assign last_drain = (chain_r == CW'(WINDOW - 2)) || !sts.nxt_valid;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    chain_nxt = chain_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_STEPS - 1)) state_nxt = ST_ACK;
      end
      ST_ACK: begin
        if (!sts.chk_ok) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          state_nxt = last_ack ? ST_IDLE : ST_DELIV;
        end
      end
      ST_DELIV: begin
        chain_nxt = '0;
        if (sts.out_free) state_nxt = last_deliv ? ST_IDLE : ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          chain_nxt = chain_r + 1'b1;
          if (last_drain) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.step = step_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
      end
      ST_SUM: cmd.add = 1'b1;
      ST_ACK: begin
        cmd.emit_ack = sts.chk_ok && sts.out_free;
        cmd.last     = last_ack;
      end
      ST_DELIV: begin
        cmd.emit_pkt = sts.out_free;
        cmd.last     = last_deliv;
      end
      ST_DRAIN: begin
        cmd.emit_buf = sts.out_free;
        cmd.last     = last_drain;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      chain_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      chain_r <= chain_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/srr_dp.sv
`default_nettype none

module srr_dp #(
  parameter int WINDOW        = 8,
  parameter int PAYLOAD_BYTES = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire srr_pkg::srr_in_t          in_data,
  input  wire logic [srr_pkg::WS_W-1:0]  window_size,
  input  wire srr_pkg::srr_cmd_t         cmd,
  output srr_pkg::srr_sts_t              sts,
  srr_out_if.source                      out_res
);
  import srr_pkg::*;

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WIN_W = $clog2(WINDOW + 1);

  logic [SEQ_W-1:0] seq_r;
  logic [CHK_W-1:0] chk_r, sum_r, sum_add;
  logic [PAY_W-1:0] pay_r, pay_in, pay_m, rd_data_r;
  logic [PAY_W-1:0] mem [WINDOW];
  logic [SEQ_W-1:0] exp_r, exp_nxt, off;
  logic [AW-1:0]    slot_r, slot_nxt, st_slot;
  logic [AW:0]      slot_sum;
  logic [WIN_W-1:0] w_eff;
  logic [WINDOW-1:0] valid_r;
  logic [7:0]       byte_v;
  logic             store, advance;
  logic             out_valid_r;
  srr_out_t         out_data_r, out_data_nxt;

  assign pay_in = {in_data.payload_hi, in_data.payload_mid, in_data.payload_lo};

  always_comb begin
    pay_m = '0;
    for (int b = 0; b < PAY_MAX; b++) begin
      if (b < PAYLOAD_BYTES) pay_m[b*8 +: 8] = pay_in[b*8 +: 8];
    end
  end

  always_comb begin
    sum_add = sum_r;
    byte_v  = '0;
    for (int j = 0; j < SUM_LANES; j++) begin
      byte_v  = pay_r[{cmd.step, 2'(j), 3'b000} +: 8];
      sum_add = sum_add + {{(CHK_W - 8){byte_v[7]}}, byte_v};
    end
  end

  assign off   = seq_r - exp_r;
  assign w_eff = (int'(window_size) > WINDOW) ? WIN_W'(WINDOW) : WIN_W'(window_size);

  // seq ahead without wrap: offset from the expected slot; across wrap seq itself is small
  always_comb begin
    slot_sum = (AW + 1)'(slot_r) + (AW + 1)'(off[AW-1:0]);
    if (slot_sum >= (AW + 1)'(WINDOW)) slot_sum = slot_sum - (AW + 1)'(WINDOW);
    st_slot = (seq_r >= exp_r) ? slot_sum[AW-1:0] : seq_r[AW-1:0];
  end

  assign exp_nxt  = exp_r + 1'b1;
  assign slot_nxt = ((exp_nxt == '0) || (slot_r == AW'(WINDOW - 1))) ? '0 : slot_r + 1'b1;

  assign sts.chk_ok    = (sum_r == chk_r);
  assign sts.in_win    = (off < SEQ_W'(w_eff));
  assign sts.in_order  = (off == '0);
  assign sts.nxt_valid = valid_r[slot_nxt] && (slot_nxt != slot_r);
  assign sts.out_free  = !out_valid_r || out_res.ready;

  assign store   = cmd.emit_ack && sts.in_win && !sts.in_order;
  assign advance = cmd.emit_pkt || cmd.emit_buf;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= in_data.seq_number;
      chk_r <= in_data.checksum_in;
      pay_r <= pay_m;
      sum_r <= CHK_W'(in_data.seq_number) + CHK_W'(in_data.ack_number_in);
    end else if (cmd.add) begin
      sum_r <= sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (store) mem[st_slot] <= pay_r;
    if (advance) rd_data_r <= mem[slot_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= '0;
      slot_r  <= '0;
      valid_r <= '0;
    end else begin
      if (store) valid_r[st_slot] <= 1'b1;
      if (advance) begin
        valid_r[slot_r] <= 1'b0;
        exp_r           <= exp_nxt;
        slot_r          <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ack || advance) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (cmd.emit_ack) begin
      out_data_nxt              = '0;
      out_data_nxt.kind         = KIND_ACK;
      out_data_nxt.ack_out      = seq_r;
      out_data_nxt.ack_checksum = $signed(CHK_W'(seq_r));
      out_data_nxt.last         = cmd.last;
    end else if (advance) begin
      out_data_nxt      = '0;
      out_data_nxt.kind = KIND_DATA;
      out_data_nxt.last = cmd.last;
      {out_data_nxt.deliver_hi, out_data_nxt.deliver_mid, out_data_nxt.deliver_lo} =
        cmd.emit_pkt ? pay_r : rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_ack_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_ACK) |->
      (out_data_r.ack_checksum == $signed(CHK_W'(out_data_r.ack_out))))
    else $error("ACK checksum differs from ACK number");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == KIND_DATA) |->
      (out_data_r.ack_out == '0 && out_data_r.ack_checksum == '0))
    else $error("delivery carries ACK fields");

  a_exp_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (exp_r == $past(exp_r) + 1'b1))
    else $error("expected sequence skipped");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(slot_r) < WINDOW)
    else $error("expected slot out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/selective_repeat_receiver.sv
`default_nettype none

// Channel  Dir  Handshake      Payload
// in_pkt   in   valid/ready    srr_in_t: seq, ack, checksum, 20-byte payload
// out_res  out  valid/ready    srr_out_t: ACK or delivered payload, last flag
// cfg_*    in   APB, pready=1  window_size at byte address 0
//
// One packet at a time: accept, then the checksum at 4 bytes per cycle,
// then the results in order (ACK, then up to WINDOW deliveries), each held while out_res stalls;
// a packet that fails its checksum is dropped with no result.
// Buffered deliveries come from the reorder memory, one registered read per result.
// Output is registered; a stalled out_res holds the block in its current result.
// Synchronous active-low reset clears the window state and valid marks at once.

module selective_repeat_receiver #(
  parameter int WINDOW        = 8,
  parameter int PAYLOAD_BYTES = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  srr_in_if.sink                             in_pkt,
  srr_out_if.source                          out_res,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [srr_pkg::APB_AW-1:0]    cfg_paddr,
  input  wire logic [srr_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic      [srr_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import srr_pkg::*;

  logic [WS_W-1:0] window_size_r;
  srr_cmd_t        cmd;
  srr_sts_t        sts;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_WS) ? APB_DW'(window_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_RESET;
    end else if (cfg_wr && cfg_paddr == CFG_ADDR_WS) begin
      window_size_r <= cfg_pwdata[WS_W-1:0];
    end
  end

  srr_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pkt.valid),
    .in_ready (in_pkt.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srr_dp #(
    .WINDOW        (WINDOW),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_pkt.data),
    .window_size (window_size_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_res     (out_res)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srr_pkg::*;

  localparam int WIN          = 8;
  localparam int PAY_BYTES    = 20;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int N_PHASES     = 7;
  // window settings per phase, phase 0 in the low nibble
  localparam logic [N_PHASES*WS_W-1:0] WIN_SETTINGS =
    {4'd8, 4'd6, 4'd3, 4'd0, 4'd15, 4'd1, 4'd8};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  srr_in_if  in_bus ();
  srr_out_if out_bus ();

  selective_repeat_receiver u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pkt      (in_bus),
    .out_res     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // receiver state as the block should hold it
  logic [WS_W-1:0]  win_reg;
  logic [SEQ_W-1:0] next_seq;
  logic [WIN-1:0]   slot_vld;
  logic [PAY_W-1:0] slot_pay [WIN];

  srr_out_t expected_results [$];
  srr_in_t  pkt_pending [$];

  logic [SEQ_W-1:0] gen_base;
  int               n_queued;
  int               n_valid_queued;
  int               n_accepted;
  int               n_dropped;
  int               n_acks_seen;
  int               n_deliv_seen;
  int               longest_chain;
  int               errors;
  int               cycle_cnt;
  int               hold_left;
  bit               hold_done;
  bit               hold_req;
  bit               calm;

  always #6ns clk = ~clk;

  function automatic logic [31:0] pkt_sum(logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ackn,
                                          logic [63:0] lo, logic [63:0] mid,
                                          logic [31:0] hi);
    logic [PAY_W-1:0] pay;
    logic [31:0]      s;
    pay = {hi, mid, lo};
    s = {1'b0, seq} + {1'b0, ackn};
    for (int i = 0; i < PAY_BYTES; i++) s += {{24{pay[8*i+7]}}, pay[8*i +: 8]};
    return s;
  endfunction

  function automatic void predict_results(srr_in_t p);
    srr_out_t         batch [$];
    srr_out_t         r;
    logic [PAY_W-1:0] pay;
    logic [SEQ_W-1:0] off;
    int unsigned      w;
    int               chain;
    if (pkt_sum(p.seq_number, p.ack_number_in, p.payload_lo, p.payload_mid, p.payload_hi)
        != p.checksum_in) begin
      n_dropped++;
      return;
    end
    pay = {p.payload_hi, p.payload_mid, p.payload_lo};
    for (int i = PAY_BYTES; i < PAY_MAX; i++) pay[8*i +: 8] = 8'h00;
    r = '0;
    r.kind = KIND_ACK;
    r.ack_out = p.seq_number;
    r.ack_checksum = {1'b0, p.seq_number};
    batch = {batch, r};
    w = (win_reg > WIN) ? WIN : win_reg;
    off = p.seq_number - next_seq;
    if (off < w) begin
      if (off == 0) begin
        chain = 0;
        do begin
          r = '0;
          r.kind = KIND_DATA;
          {r.deliver_hi, r.deliver_mid, r.deliver_lo} =
            (chain == 0) ? pay : slot_pay[next_seq % WIN];
          batch = {batch, r};
          slot_vld[next_seq % WIN] = 1'b0;
          next_seq = next_seq + 1'b1;
          chain++;
        end while (chain < WIN && slot_vld[next_seq % WIN]);
        if (chain > longest_chain) longest_chain = chain;
      end else begin
        slot_vld[p.seq_number % WIN] = 1'b1;
        slot_pay[p.seq_number % WIN] = pay;
      end
    end
    foreach (batch[i]) begin
      r = batch[i];
      r.last = (i == batch.size() - 1);
      expected_results = {expected_results, r};
    end
  endfunction

  task automatic cmp_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  task automatic check_result(srr_out_t got);
    srr_out_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    cmp_field("kind", 64'(want.kind), 64'(got.kind));
    cmp_field("ack_out", 64'(want.ack_out), 64'(got.ack_out));
    cmp_field("ack_checksum", {32'b0, want.ack_checksum}, {32'b0, got.ack_checksum});
    cmp_field("deliver_lo", want.deliver_lo, got.deliver_lo);
    cmp_field("deliver_mid", want.deliver_mid, got.deliver_mid);
    cmp_field("deliver_hi", 64'(want.deliver_hi), 64'(got.deliver_hi));
    cmp_field("last", 64'(want.last), 64'(got.last));
  endtask

  task automatic push_raw(logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] ackn, logic [63:0] lo,
                          logic [63:0] mid, logic [31:0] hi, bit corrupt);
    srr_in_t p;
    p.seq_number    = seq;
    p.ack_number_in = ackn;
    p.payload_lo    = lo;
    p.payload_mid   = mid;
    p.payload_hi    = hi;
    p.checksum_in   = pkt_sum(seq, ackn, lo, mid, hi);
    if (corrupt) p.checksum_in = p.checksum_in ^ (32'd1 << $urandom_range(31));
    else n_valid_queued++;
    pkt_pending = {pkt_pending, p};
    n_queued++;
  endtask

  task automatic push_pkt(logic [SEQ_W-1:0] seq, bit corrupt);
    push_raw(seq, SEQ_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
             corrupt);
  endtask

  // one window's worth of sequence numbers in shuffled order, with corrupt copies,
  // repeats and stray packets mixed in; with a zero window, four packets near the base
  task automatic send_block(int w);
    logic [SEQ_W-1:0] order [WIN];
    logic [SEQ_W-1:0] t;
    int               j;
    if (w == 0) begin
      repeat (4) push_pkt(gen_base + SEQ_W'($urandom_range(7)), $urandom_range(4) == 0);
      return;
    end
    for (int k = 0; k < w; k++) order[k] = gen_base + SEQ_W'(k);
    for (int k = w - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int k = 0; k < w; k++) begin
      if ($urandom_range(9) == 0) push_pkt(order[k], 1'b1);
      push_pkt(order[k], 1'b0);
      if ($urandom_range(7) == 0) push_pkt(order[k], 1'b0);
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1) == 0) push_pkt(gen_base - 1'b1 - SEQ_W'($urandom_range(20)), 1'b0);
        else push_pkt(SEQ_W'($urandom), 1'b0);
      end
    end
    gen_base += SEQ_W'(w);
  endtask

  task automatic cfg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    win_reg = val[WS_W-1:0];
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.data  <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_results(in_bus.data);
        n_accepted++;
      end
      if (in_bus.valid && !in_bus.ready) begin
        in_bus.valid <= 1'b1;
      end else if (pkt_pending.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
        in_bus.valid <= 1'b1;
        in_bus.data  <= pkt_pending.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_bus.ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (out_bus.data.kind == KIND_ACK) n_acks_seen++;
      else n_deliv_seen++;
      check_result(out_bus.data);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned weff;
    int          target;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    win_reg       = WS_RESET;
    next_seq      = '0;
    slot_vld      = '0;
    gen_base      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bad checksum, payload and checksum extremes, reorder, overwrite, full chain
    push_raw('0, '0, '0, '0, '0, 1'b1);
    push_raw('0, {SEQ_W{1'b1}}, '1, '1, '1, 1'b0);
    push_raw({SEQ_W{1'b1}}, '0, '0, '0, '0, 1'b0);
    push_raw({SEQ_W{1'b1}}, 31'd1, '0, '0, '0, 1'b0);
    push_raw(31'd3, '0, {8{8'h80}}, {8{8'h80}}, {4{8'h80}}, 1'b0);
    push_raw(31'd2, {SEQ_W{1'b1}}, {8{8'h7f}}, {8{8'h7f}}, {4{8'h7f}}, 1'b0);
    push_pkt(31'd3, 1'b0);
    push_pkt(31'd1, 1'b1);
    push_pkt(31'd1, 1'b0);
    push_pkt(31'd1, 1'b0);
    for (int k = 5; k < 12; k++) push_pkt(SEQ_W'(k), 1'b0);
    push_pkt(31'd4, 1'b0);
    push_pkt(31'd20, 1'b0);
    push_pkt(31'd19, 1'b0);
    push_pkt(31'd0, 1'b0);
    gen_base = 31'd12;

    for (int k = 0; k < N_PHASES; k++) begin
      wait_drained();
      cfg_write(CFG_ADDR_WS, APB_DW'(WIN_SETTINGS[WS_W*k +: WS_W]));
      calm <= (k == 4);
      weff = (win_reg > WIN) ? WIN : win_reg;
      target = n_valid_queued + ((weff == 0) ? 20 : 46);
      while (n_valid_queued < target) send_block(weff);
      if (k == 2) hold_req <= 1'b1;
    end
    wait_drained();

    $display("tb_top: %0d packets transferred, %0d failed checksum; %0d ACKs, %0d deliveries",
             n_accepted, n_dropped, n_acks_seen, n_deliv_seen);
    $display("tb_top: windows 8,1,15,0,3,6,8 with one long output stall; longest run %0d",
             longest_chain);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
